>>> rtl/bpr_pkg.sv
// ---------------------------------------------------------------------------
// bpr_pkg: shared types and constants for budget period rollover
// Status codes, the classified record carried through the queue, and the
// per-stage record carried through the divider pipeline.
// ---------------------------------------------------------------------------
package bpr_pkg;

    localparam int DivSteps = 64;
    localparam int FifoDepth = 2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_LEN  = 3'd1;
    localparam logic [2:0] ST_REGRESS   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_OVERSPENT = 3'd4;

    typedef struct packed {
        logic [2:0]   err;
        logic [63:0]  diff;
        logic [63:0]  len;
        logic [63:0]  start;
        logic [127:0] limit;
        logic [127:0] spent;
        logic [127:0] base;
        logic [127:0] cap;
        logic         capped;
        logic [127:0] unspent;
        logic         overspent;
    } bpr_item_t;

    typedef struct packed {
        bpr_item_t    item;
        logic [127:0] rq;       // {remainder, dividend/quotient}
        logic [127:0] carry;
        logic [127:0] sum;
        logic         ovf;
    } bpr_stage_t;

    // one restoring division step
    function automatic logic [127:0] bpr_div_step(logic [127:0] rq, logic [63:0] d);
        logic [64:0] r2;
        logic [64:0] rs;
        logic        ge;
        r2 = {rq[127:64], rq[63]};
        ge = (r2 >= {1'b0, d});
        rs = ge ? (r2 - {1'b0, d}) : r2;
        return {rs[63:0], rq[62:0], ge};
    endfunction

endpackage

>>> rtl/bpr_front.sv
// ---------------------------------------------------------------------------
// bpr_front: record classifier
// Flags malformed length and time regression, selects the base limit,
// computes elapsed time and unspent amount, and pushes into the queue.
// ---------------------------------------------------------------------------
module bpr_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          batch_time,
    input  logic [63:0]          window_start,
    input  logic [63:0]          window_len,
    input  logic [127:0]         limit,
    input  logic [127:0]         spent,
    input  logic [127:0]         base_limit,
    input  logic [127:0]         cap,
    input  logic                 capped_policy,
    output logic                 push_valid,
    input  logic                 push_ready,
    output bpr_pkg::bpr_item_t   push_item
);

    always_comb
    begin
        push_valid = in_valid;
        in_ready   = push_ready;
        if (window_len == 64'd0)
            push_item.err = bpr_pkg::ST_ZERO_LEN;
        else if (batch_time < window_start)
            push_item.err = bpr_pkg::ST_REGRESS;
        else
            push_item.err = bpr_pkg::ST_OK;
        push_item.diff      = batch_time - window_start;
        push_item.len       = window_len;
        push_item.start     = window_start;
        push_item.limit     = limit;
        push_item.spent     = spent;
        push_item.base      = (base_limit == 128'd0) ? limit : base_limit;
        push_item.cap       = cap;
        push_item.capped    = capped_policy;
        push_item.unspent   = limit - spent;
        push_item.overspent = (spent > limit);
    end

endmodule

>>> rtl/bpr_fifo.sv
// ---------------------------------------------------------------------------
// bpr_fifo: short queue between classifier and divider back end
// Two entries; lets the front keep accepting while the back stalls.
// ---------------------------------------------------------------------------
module bpr_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  bpr_pkg::bpr_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output bpr_pkg::bpr_item_t   pop_item
);

    localparam int PtrW = $clog2(bpr_pkg::FifoDepth);

    bpr_pkg::bpr_item_t mem_reg [bpr_pkg::FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != PtrW'(0) + (PtrW+1)'(bpr_pkg::FifoDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PtrW+1)'(bpr_pkg::FifoDepth))
        else $error("queue count beyond depth");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!push_ready && !do_pop) |=> (count_reg == $past(count_reg)))
        else $error("queue count moved while full");
    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !do_pop)
        else $error("pop from empty queue");

endmodule

>>> rtl/bpr_back.sv
// ---------------------------------------------------------------------------
// bpr_back: divider pipeline and result formation
// 64 restoring division stages, one quotient bit each; the carry cap and
// new-limit add ride along in the first two stages. Output register last.
// ---------------------------------------------------------------------------
module bpr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  bpr_pkg::bpr_item_t   pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic                 rolled,
    output logic [63:0]          periods_elapsed,
    output logic [63:0]          new_period_start,
    output logic [127:0]         new_limit,
    output logic [127:0]         new_spent,
    output logic [127:0]         carry
);

    localparam int N = bpr_pkg::DivSteps;

    bpr_pkg::bpr_stage_t st_reg  [N];
    bpr_pkg::bpr_stage_t st_next [N];
    logic [N-1:0]        vld_reg;
    logic                adv;

    logic                out_valid_reg;
    logic [2:0]          status_reg, status_next;
    logic                rolled_reg, rolled_next;
    logic [63:0]         periods_reg, periods_next;
    logic [63:0]         start_reg, start_next;
    logic [127:0]        limit_reg, limit_next;
    logic [127:0]        spent_reg, spent_next;
    logic [127:0]        carry_reg, carry_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            bpr_pkg::bpr_stage_t src;
            if (g == 0)
            begin : g_first
                always_comb
                begin
                    src.item  = pop_item;
                    src.rq    = {64'd0, pop_item.diff};
                    src.carry = '0;
                    if (pop_item.capped)
                        src.carry = (pop_item.unspent > pop_item.cap) ?
                                    pop_item.cap : pop_item.unspent;
                    src.sum   = '0;
                    src.ovf   = 1'b0;
                end
            end
            else if (g == 1)
            begin : g_second
                logic [128:0] s;
                always_comb
                begin
                    src     = st_reg[g-1];
                    s       = {1'b0, src.item.base} + {1'b0, src.carry};
                    src.sum = s[127:0];
                    src.ovf = s[128];
                end
            end
            else
            begin : g_mid
                assign src = st_reg[g-1];
            end
            always_comb
            begin
                st_next[g]    = src;
                st_next[g].rq = bpr_pkg::bpr_div_step(src.rq, src.item.len);
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // result formation from the last divider stage
    always_comb
    begin
        bpr_pkg::bpr_stage_t l;
        l            = st_reg[N-1];
        status_next  = bpr_pkg::ST_OK;
        rolled_next  = 1'b0;
        periods_next = l.rq[63:0];
        start_next   = l.item.start;
        limit_next   = l.item.limit;
        spent_next   = l.item.spent;
        carry_next   = '0;
        if (l.item.err != bpr_pkg::ST_OK)
        begin
            status_next  = l.item.err;
            periods_next = '0;
        end
        else if (l.rq[63:0] == 64'd0)
        begin
            status_next = bpr_pkg::ST_OK;
        end
        else if (l.item.overspent)
        begin
            status_next = bpr_pkg::ST_OVERSPENT;
        end
        else if (l.ovf)
        begin
            status_next = bpr_pkg::ST_OVERFLOW;
        end
        else
        begin
            // start + periods*len == batch_time - remainder, never overflows
            rolled_next = 1'b1;
            start_next  = l.item.start + (l.item.diff - l.rq[127:64]);
            limit_next  = l.sum;
            spent_next  = '0;
            carry_next  = l.carry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg  <= status_next;
            rolled_reg  <= rolled_next;
            periods_reg <= periods_next;
            start_reg   <= start_next;
            limit_reg   <= limit_next;
            spent_reg   <= spent_next;
            carry_reg   <= carry_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign rolled           = rolled_reg;
    assign periods_elapsed  = periods_reg;
    assign new_period_start = start_reg;
    assign new_limit        = limit_reg;
    assign new_spent        = spent_reg;
    assign carry            = carry_reg;

    a_roll_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rolled) |-> (status == bpr_pkg::ST_OK && new_spent == '0))
        else $error("rolled result with bad status or spent");
    a_no_roll_no_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rolled) |-> (carry == '0))
        else $error("carry without rollover");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(new_limit)))
        else $error("stalled result changed");
    a_roll_periods: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rolled) |-> (periods_elapsed != '0))
        else $error("rollover with zero periods");

endmodule

>>> rtl/budget_period_rollover.sv
// ---------------------------------------------------------------------------
// budget_period_rollover: periodic quota rollover with capped carry
// Top level: classifier, queue, divider back end.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one budget record and a batch
//   time per transaction; output channel out_valid/out_ready returns one
//   result per record, in order.
//   An accepted record passes through the two-entry queue, then the
//   64-stage restoring divider (one quotient bit per stage) that forms the
//   elapsed period count, and then the output register before result valid.
//   Throughput is one record per cycle while out_ready stays high.
//   When the receiver stalls, the divider pipeline and output register hold;
//   the queue absorbs up to two more records, then in_ready drops.
//   Reset clears all valid state; no records are in flight after reset.
// ---------------------------------------------------------------------------
module budget_period_rollover (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  batch_time,
    input  logic [63:0]  window_start,
    input  logic [63:0]  window_len,
    input  logic [63:0]  limit_lo,
    input  logic [63:0]  limit_hi,
    input  logic [63:0]  spent_lo,
    input  logic [63:0]  spent_hi,
    input  logic [63:0]  base_limit_lo,
    input  logic [63:0]  base_limit_hi,
    input  logic [63:0]  cap_lo,
    input  logic [63:0]  cap_hi,
    input  logic         capped_policy,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   status,
    output logic         rolled,
    output logic [63:0]  periods_elapsed,
    output logic [63:0]  new_period_start,
    output logic [63:0]  new_limit_lo,
    output logic [63:0]  new_limit_hi,
    output logic [63:0]  new_spent_lo,
    output logic [63:0]  new_spent_hi,
    output logic [63:0]  carry_lo,
    output logic [63:0]  carry_hi
);

    logic               push_valid, push_ready, pop_valid, pop_ready;
    bpr_pkg::bpr_item_t push_item, pop_item;
    logic [127:0]       new_limit, new_spent, carry;

    bpr_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .batch_time    (batch_time),
        .window_start  (window_start),
        .window_len    (window_len),
        .limit         ({limit_hi, limit_lo}),
        .spent         ({spent_hi, spent_lo}),
        .base_limit    ({base_limit_hi, base_limit_lo}),
        .cap           ({cap_hi, cap_lo}),
        .capped_policy (capped_policy),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    bpr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    bpr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .rolled           (rolled),
        .periods_elapsed  (periods_elapsed),
        .new_period_start (new_period_start),
        .new_limit        (new_limit),
        .new_spent        (new_spent),
        .carry            (carry)
    );

    assign new_limit_lo = new_limit[63:0];
    assign new_limit_hi = new_limit[127:64];
    assign new_spent_lo = new_spent[63:0];
    assign new_spent_hi = new_spent[127:64];
    assign carry_lo     = carry[63:0];
    assign carry_hi     = carry[127:64];

endmodule
